### hw/rtl/rrs_pkg.sv
// ----------------------------------------------------------------------------
// Rounded rectangle span package
// Shared types and constants of the rounded rectangle span generator.
// ----------------------------------------------------------------------------
package rrs_pkg;

   localparam int CoordWidth  = 12;
   localparam int RadiusWidth = 5;
   localparam int CsrIdxWidth = 3;
   localparam int QueueDepth  = 2;

   typedef logic [CoordWidth-1:0]  coord_type;
   typedef logic [RadiusWidth-1:0] radius_type;

   typedef enum logic [1:0] {
      KIND_RECT     = 2'd0,
      KIND_RESET    = 2'd1,
      KIND_EMPTY    = 2'd2,
      KIND_NOCHANGE = 2'd3
   } kind_type;

   typedef enum logic [CsrIdxWidth-1:0] {
      CSR_RADIUS_TL = 3'd0,
      CSR_RADIUS_TR = 3'd1,
      CSR_RADIUS_BR = 3'd2,
      CSR_RADIUS_BL = 3'd3,
      CSR_ROUND_MAX = 3'd4
   } csr_index_type;

   typedef enum logic [1:0] {
      PH_TOP = 2'd0,
      PH_MID = 2'd1,
      PH_BOT = 2'd2
   } phase_type;

   typedef enum logic [3:0] {
      BK_IDLE,
      BK_STATUS,
      BK_ROW,
      BK_PREP,
      BK_SQRT,
      BK_ROUND,
      BK_MID,
      BK_EMIT,
      BK_FINISH
   } back_state_type;

   typedef struct packed {
      logic       is_status;
      kind_type   kind;
      coord_type  width;
      coord_type  height;
      radius_type tl;
      radius_type tr;
      radius_type bl;
      radius_type br;
      radius_type top;
      radius_type bot;
   } job_type;

   typedef struct packed {
      coord_type x;
      coord_type y;
      coord_type w;
      coord_type h;
   } span_type;

endpackage

### hw/rtl/rrs_queue.sv
// ----------------------------------------------------------------------------
// Job queue
// Small first-in first-out buffer of classified jobs between front and back.
// ----------------------------------------------------------------------------
module rrs_queue import rrs_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_data,
   output logic    full,
   input  logic    pop,
   output job_type pop_data,
   output logic    empty
);

   job_type    entry_ff [QueueDepth];
   logic       wr_ptr_ff, rd_ptr_ff;
   logic [1:0] count_ff;

   assign full     = (count_ff == 2'(QueueDepth));
   assign empty    = (count_ff == 2'd0);
   assign pop_data = entry_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) wr_ptr_ff <= ~wr_ptr_ff;
         if (pop) rd_ptr_ff <= ~rd_ptr_ff;
         if (push && !pop) count_ff <= count_ff + 2'd1;
         else if (pop && !push) count_ff <= count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) entry_ff[wr_ptr_ff] <= push_data;
   end

endmodule

### hw/rtl/rrs_front.sv
// ----------------------------------------------------------------------------
// Front end
// Holds the configuration registers and classifies each frame transaction
// into a status answer or a span job with saturated radii and band heights.
// ----------------------------------------------------------------------------
module rrs_front import rrs_pkg::*; #(
   parameter int MAX_RADIUS = 31
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CsrIdxWidth-1:0] csr_index,
   input  logic [7:0]             csr_data,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  coord_type              in_width,
   input  coord_type              in_height,
   input  logic                   in_maximized,
   input  logic                   in_fills,
   output logic                   push,
   output job_type                push_data,
   input  logic                   full
);

   localparam radius_type MaxR = RadiusWidth'(MAX_RADIUS);

   logic [7:0] rad_tl_ff, rad_tr_ff, rad_br_ff, rad_bl_ff;
   logic       round_max_ff;

   radius_type tl, tr, br, bl, top0, bot0, half;
   logic [5:0] sum, excess;
   job_type    job;

   assign csr_ready = 1'b1;
   assign in_ready  = !full;
   assign push      = in_valid && !full;
   assign push_data = job;

   always_ff @(posedge clock) begin
      if (reset) begin
         rad_tl_ff    <= 8'd0;
         rad_tr_ff    <= 8'd0;
         rad_br_ff    <= 8'd0;
         rad_bl_ff    <= 8'd0;
         round_max_ff <= 1'b1;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_RADIUS_TL: rad_tl_ff <= csr_data;
            CSR_RADIUS_TR: rad_tr_ff <= csr_data;
            CSR_RADIUS_BR: rad_br_ff <= csr_data;
            CSR_RADIUS_BL: rad_bl_ff <= csr_data;
            CSR_ROUND_MAX: round_max_ff <= csr_data[0];
            default: ;
         endcase
      end
   end

   function automatic radius_type sat(input logic [7:0] r);
      return (r > 8'(MAX_RADIUS)) ? MaxR : r[RadiusWidth-1:0];
   endfunction

   always_comb begin
      tl     = sat(rad_tl_ff);
      tr     = sat(rad_tr_ff);
      br     = sat(rad_br_ff);
      bl     = sat(rad_bl_ff);
      top0   = (tl > tr) ? tl : tr;
      bot0   = (bl > br) ? bl : br;
      sum    = {1'b0, top0} + {1'b0, bot0};
      excess = sum - in_height[5:0];
      half   = RadiusWidth'((excess + 6'd1) >> 1);

      job           = '0;
      job.width     = in_width;
      job.height    = in_height;
      job.tl        = tl;
      job.tr        = tr;
      job.bl        = bl;
      job.br        = br;
      job.top       = top0;
      job.bot       = bot0;
      job.kind      = KIND_RECT;
      job.is_status = 1'b0;
      if (CoordWidth'(sum) > in_height) begin
         job.top = (top0 > half) ? top0 - half : '0;
         job.bot = (bot0 > half) ? bot0 - half : '0;
      end
      priority if (((rad_tl_ff | rad_tr_ff | rad_br_ff | rad_bl_ff) == 8'd0) ||
                   (in_maximized && !round_max_ff) || in_fills) begin
         job.is_status = 1'b1;
         job.kind      = KIND_RESET;
      end else if (in_width == '0 || in_height == '0) begin
         job.is_status = 1'b1;
         job.kind      = KIND_NOCHANGE;
      end else begin
         job.is_status = 1'b0;
      end
   end

endmodule

### hw/rtl/rrs_back.sv
// ----------------------------------------------------------------------------
// Back end
// Walks the corner rows of one job, computes each inset with a bit-serial
// rounded square root and delivers the spans through an output register.
// ----------------------------------------------------------------------------
module rrs_back import rrs_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      empty,
   input  job_type   pop_data,
   output logic      pop,
   output logic      out_valid,
   input  logic      out_ready,
   output kind_type  out_kind,
   output span_type  out_span,
   output logic      out_last
);

   back_state_type state_ff, state_in;
   job_type        job_ff;
   phase_type      phase_ff, phase_in;
   radius_type     y_ff, y_in;
   logic           side_ff, side_in;
   logic [9:0]     v_ff, v_in;
   logic           zero_ff, zero_in;
   radius_type     s_ff, s_in;
   logic [2:0]     bit_ff, bit_in;
   radius_type     li_ff, li_in;
   span_type       span_ff, span_in;
   span_type       pend_ff, pend_in;
   logic           pend_valid_ff, pend_valid_in;
   logic           out_valid_ff, out_valid_in;
   kind_type       out_kind_ff, out_kind_in;
   span_type       out_span_ff, out_span_in;
   logic           out_last_ff, out_last_in;

   logic          out_free;
   radius_type    cur_r, cur_yy, dy, trial, root, inset;
   logic [9:0]    trial_sq, s_sq;
   logic [10:0]   s_lim;
   coord_type     row, span_w;
   logic [13:0]   mid_h;

   assign out_free  = !out_valid_ff || out_ready;
   assign out_valid = out_valid_ff;
   assign out_kind  = out_kind_ff;
   assign out_span  = out_span_ff;
   assign out_last  = out_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= BK_IDLE;
         pend_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         pend_valid_ff <= pend_valid_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) job_ff <= pop_data;
      phase_ff    <= phase_in;
      y_ff        <= y_in;
      side_ff     <= side_in;
      v_ff        <= v_in;
      zero_ff     <= zero_in;
      s_ff        <= s_in;
      bit_ff      <= bit_in;
      li_ff       <= li_in;
      span_ff     <= span_in;
      pend_ff     <= pend_in;
      out_kind_ff <= out_kind_in;
      out_span_ff <= out_span_in;
      out_last_ff <= out_last_in;
   end

   always_comb begin
      if (phase_ff == PH_TOP) begin
         cur_r  = side_ff ? job_ff.tr : job_ff.tl;
         cur_yy = y_ff;
         row    = CoordWidth'(y_ff);
      end else begin
         cur_r  = side_ff ? job_ff.br : job_ff.bl;
         cur_yy = job_ff.bot - 5'd1 - y_ff;
         row    = job_ff.height - CoordWidth'(job_ff.bot) + CoordWidth'(y_ff);
      end
      dy       = cur_r - cur_yy;
      trial    = s_ff | RadiusWidth'(5'd1 << bit_ff);
      trial_sq = 10'(trial * trial);
      s_sq     = 10'(s_ff * s_ff);
      s_lim    = {1'b0, s_sq} + 11'(s_ff);
      root     = ({1'b0, v_ff} > s_lim) ? s_ff + 5'd1 : s_ff;
      if (root > cur_r) root = cur_r;
      inset    = zero_ff ? '0 : cur_r - root;
      span_w   = job_ff.width - CoordWidth'(inset) - CoordWidth'(li_ff);
      mid_h    = {2'b0, job_ff.height} - 14'(job_ff.top) - 14'(job_ff.bot);
   end

   always_comb begin
      state_in      = state_ff;
      phase_in      = phase_ff;
      y_in          = y_ff;
      side_in       = side_ff;
      v_in          = v_ff;
      zero_in       = zero_ff;
      s_in          = s_ff;
      bit_in        = bit_ff;
      li_in         = li_ff;
      span_in       = span_ff;
      pend_in       = pend_ff;
      pend_valid_in = pend_valid_ff;
      out_valid_in  = out_valid_ff && !out_ready;
      out_kind_in   = out_kind_ff;
      out_span_in   = out_span_ff;
      out_last_in   = out_last_ff;
      pop           = 1'b0;

      unique case (state_ff)
         BK_IDLE: begin
            if (!empty) begin
               pop      = 1'b1;
               phase_in = PH_TOP;
               y_in     = '0;
               state_in = pop_data.is_status ? BK_STATUS : BK_ROW;
            end
         end
         BK_STATUS: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_kind_in  = job_ff.kind;
               out_span_in  = '0;
               out_last_in  = 1'b1;
               state_in     = BK_IDLE;
            end
         end
         BK_ROW: begin
            side_in = 1'b0;
            priority if (phase_ff == PH_TOP && y_ff >= job_ff.top) begin
               state_in = BK_MID;
            end else if (phase_ff == PH_BOT && y_ff >= job_ff.bot) begin
               state_in = BK_FINISH;
            end else begin
               state_in = BK_PREP;
            end
         end
         BK_PREP: begin
            zero_in  = (cur_r == '0) || (cur_yy >= cur_r);
            v_in     = 10'(cur_r * cur_r) - 10'(dy * dy);
            s_in     = '0;
            bit_in   = 3'(RadiusWidth - 1);
            state_in = BK_SQRT;
         end
         BK_SQRT: begin
            if (trial_sq <= v_ff) s_in = trial;
            bit_in = bit_ff - 3'd1;
            if (bit_ff == 3'd0) state_in = BK_ROUND;
         end
         BK_ROUND: begin
            if (!side_ff) begin
               li_in    = inset;
               side_in  = 1'b1;
               state_in = BK_PREP;
            end else begin
               span_in = '{x: CoordWidth'(li_ff), y: row, w: span_w, h: CoordWidth'(1)};
               if (CoordWidth'(inset) < job_ff.width &&
                   job_ff.width - CoordWidth'(inset) > CoordWidth'(li_ff)) begin
                  state_in = BK_EMIT;
               end else begin
                  y_in     = y_ff + 5'd1;
                  state_in = BK_ROW;
               end
            end
         end
         BK_MID: begin
            span_in  = '{x: '0, y: CoordWidth'(job_ff.top), w: job_ff.width,
                         h: CoordWidth'(mid_h)};
            phase_in = PH_MID;
            if (!mid_h[13] && mid_h != '0) begin
               state_in = BK_EMIT;
            end else begin
               phase_in = PH_BOT;
               y_in     = '0;
               state_in = BK_ROW;
            end
         end
         BK_EMIT: begin
            if (!pend_valid_ff || out_free) begin
               if (pend_valid_ff) begin
                  out_valid_in = 1'b1;
                  out_kind_in  = KIND_RECT;
                  out_span_in  = pend_ff;
                  out_last_in  = 1'b0;
               end
               pend_in       = span_ff;
               pend_valid_in = 1'b1;
               state_in      = BK_ROW;
               if (phase_ff == PH_MID) begin
                  phase_in = PH_BOT;
                  y_in     = '0;
               end else begin
                  y_in = y_ff + 5'd1;
               end
            end
         end
         BK_FINISH: begin
            if (out_free) begin
               out_valid_in  = 1'b1;
               out_kind_in   = pend_valid_ff ? KIND_RECT : KIND_EMPTY;
               out_span_in   = pend_valid_ff ? pend_ff : '0;
               out_last_in   = 1'b1;
               pend_valid_in = 1'b0;
               state_in      = BK_IDLE;
            end
         end
         default: state_in = BK_IDLE;
      endcase
   end

endmodule

### hw/rtl/rounded_rect_shape_spans.sv
// ----------------------------------------------------------------------------
// Rounded rectangle shape spans
// Turns a frame size into the list of rectangles that forms its rounded mask.
//
//   Channel  Direction  Contents
//   req_     in         tdata: width, height, is_maximized, fills_output
//   rsp_     out        tdata: x, y, width, height; tuser: kind; tlast: last
//   csr_     in         index 0..4 selects a radius or the maximized switch
//
// Each corner row runs the shared five-step square root once per side. A
// two-entry queue lets a new transaction be classified while the back end
// works. Reset is synchronous and clears all control state; a stalled result
// holds in the output register.
// ----------------------------------------------------------------------------
module rounded_rect_shape_spans import rrs_pkg::*; #(
   parameter int MAX_RADIUS = 31
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [31:0]            req_tdata,  // width, height, is_maximized, fills_output
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [47:0]            rsp_tdata,  // rect_x, rect_y, rect_width, rect_height
   output logic [1:0]             rsp_tuser,  // kind
   output logic                   rsp_tlast,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CsrIdxWidth-1:0] csr_index,
   input  logic [7:0]             csr_data
);

   logic     push, full, pop, empty;
   job_type  push_data, pop_data;
   kind_type out_kind;
   span_type out_span;

   rrs_front #(.MAX_RADIUS(MAX_RADIUS)) u_front (
      .clock, .reset,
      .csr_valid, .csr_ready, .csr_index, .csr_data,
      .in_valid(req_tvalid), .in_ready(req_tready),
      .in_width(req_tdata[11:0]), .in_height(req_tdata[23:12]),
      .in_maximized(req_tdata[24]), .in_fills(req_tdata[25]),
      .push, .push_data, .full
   );

   rrs_queue u_queue (
      .clock, .reset, .push, .push_data, .full, .pop, .pop_data, .empty
   );

   rrs_back u_back (
      .clock, .reset, .empty, .pop_data, .pop,
      .out_valid(rsp_tvalid), .out_ready(rsp_tready),
      .out_kind, .out_span, .out_last(rsp_tlast)
   );

   assign rsp_tuser = out_kind;
   assign rsp_tdata = {out_span.h, out_span.w, out_span.y, out_span.x};

endmodule

### hw/rtl/rrs_checker.sv
// ----------------------------------------------------------------------------
// Port checker
// Checks the result stream of the rounded rectangle span generator.
// ----------------------------------------------------------------------------
module rrs_checker import rrs_pkg::*; (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [47:0] rsp_tdata,
   input logic [1:0]  rsp_tuser,
   input logic        rsp_tlast
);

   a_status_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != KIND_RECT |-> rsp_tlast)
      else $error("status result without last");

   a_status_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != KIND_RECT |-> rsp_tdata == '0)
      else $error("status result with nonzero fields");

   a_rect_size: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == KIND_RECT |->
         rsp_tdata[35:24] != '0 && rsp_tdata[47:36] != '0)
      else $error("empty rectangle delivered");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed");

endmodule

bind rounded_rect_shape_spans rrs_checker u_rrs_checker (
   .clock, .reset, .rsp_tvalid, .rsp_tready, .rsp_tdata, .rsp_tuser, .rsp_tlast
);
